// ===== hdl/ipt_pkg.sv =====
// Shared types and constants for the indexed priority task table.
// No dependencies; every other file of the block refers to this package by scoped names.
package ipt_pkg;

  localparam int TASK_SLOTS    = 256;
  localparam int USER_BITS     = 16;
  localparam int PRIORITY_BITS = 32;
  localparam int SLOT_BITS     = $clog2(TASK_SLOTS);

  typedef logic [SLOT_BITS-1:0]     slot_idx_t;
  typedef logic [PRIORITY_BITS-1:0] prio_t;
  typedef logic [USER_BITS-1:0]     user_t;

  // Request actions
  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_EDIT   = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_EXEC   = 2'd3
  } action_t;

  typedef struct packed {
    action_t     action;
    logic [15:0] user_id;
    logic [7:0]  task_id;
    logic [31:0] priority_req;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [15:0] owner_user;
  } rsp_t;

  // Slot store write operations
  typedef enum logic [1:0] {
    SOP_NONE  = 2'd0,
    SOP_ADD   = 2'd1,
    SOP_EDIT  = 2'd2,
    SOP_CLEAR = 2'd3
  } store_op_t;

  typedef struct packed {
    store_op_t op;
    slot_idx_t idx;
    prio_t     prio;
    user_t     owner;
  } store_cmd_t;

  // One slot as seen by the scan compare unit
  typedef struct packed {
    logic      live;
    logic      valid;
    slot_idx_t idx;
    prio_t     prio;
    user_t     owner;
  } scan_sample_t;

  typedef struct packed {
    logic      have;
    slot_idx_t idx;
    user_t     owner;
  } best_t;

endpackage

// ===== hdl/ipt_store.sv =====
// Slot store: valid flags in flip-flops, priority and owner in memories.
// Depends on ipt_pkg.
module ipt_store (
  input  logic               clk,
  input  logic               rst,
  input  ipt_pkg::store_cmd_t cmd,
  input  ipt_pkg::slot_idx_t rd_addr,
  output logic               rd_valid,
  output ipt_pkg::prio_t     rd_prio,
  output ipt_pkg::user_t     rd_owner
);

  logic [ipt_pkg::TASK_SLOTS-1:0] slot_valid;
  ipt_pkg::prio_t                 prio_mem  [ipt_pkg::TASK_SLOTS];
  ipt_pkg::user_t                 owner_mem [ipt_pkg::TASK_SLOTS];

  // Valid flags, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else begin
      case (cmd.op)
        ipt_pkg::SOP_ADD:   slot_valid[cmd.idx] <= 1'b1;
        ipt_pkg::SOP_CLEAR: slot_valid[cmd.idx] <= 1'b0;
        default: ;
      endcase
    end
  end

  // Memory write port; edit only touches a live slot
  always_ff @(posedge clk) begin
    if (cmd.op == ipt_pkg::SOP_ADD) begin
      prio_mem[cmd.idx]  <= cmd.prio;
      owner_mem[cmd.idx] <= cmd.owner;
    end else if (cmd.op == ipt_pkg::SOP_EDIT && slot_valid[cmd.idx]) begin
      prio_mem[cmd.idx]  <= cmd.prio;
    end
  end

  // Registered read port for the scan
  always_ff @(posedge clk) begin
    rd_prio  <= prio_mem[rd_addr];
    rd_owner <= owner_mem[rd_addr];
    rd_valid <= slot_valid[rd_addr];
  end

endmodule

// ===== hdl/ipt_best.sv =====
// Shared compare unit: keeps the best slot seen so far during a scan.
// Depends on ipt_pkg.
module ipt_best (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  clear,
  input  ipt_pkg::scan_sample_t sample,
  output ipt_pkg::best_t        best
);

  ipt_pkg::prio_t     best_prio;
  logic               best_have;
  ipt_pkg::slot_idx_t best_idx;
  ipt_pkg::user_t     best_owner;
  logic               take;

  // Later slots win ties, hence >=
  assign take = sample.live && sample.valid && (!best_have || sample.prio >= best_prio);
  assign best = '{have: best_have, idx: best_idx, owner: best_owner};

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      best_have <= 1'b0;
    end else if (take) begin
      best_have <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_idx   <= sample.idx;
      best_owner <= sample.owner;
      best_prio  <= sample.prio;
    end
  end

endmodule

// ===== hdl/indexed_priority_task_table_top.sv =====
// Indexed priority task table, top level with the scan sequencer.
// Add, edit and remove do not stall; the next request transfers on the following edge.
// Execute top walks every slot through one memory read port and one compare unit:
// the sequencer steps through scan, drain and finish; once the output is free, the result is
// loaded as it returns to idle, so the next request can be taken while the result is shown.
// Synchronous reset clears all valid flags, the sequencer and the result valid flag.
module indexed_priority_task_table_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  ipt_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output ipt_pkg::rsp_t rsp
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  localparam ipt_pkg::slot_idx_t LAST_SLOT = ipt_pkg::SLOT_BITS'(ipt_pkg::TASK_SLOTS - 1);

  state_t                state;
  ipt_pkg::slot_idx_t    cnt;
  ipt_pkg::slot_idx_t    idx_q;
  logic                  live_q;
  logic                  accept;
  logic                  in_range;
  logic                  rsp_load;
  logic                  start_exec;
  ipt_pkg::store_cmd_t   cmd;
  logic                  rd_valid;
  ipt_pkg::prio_t        rd_prio;
  ipt_pkg::user_t        rd_owner;
  ipt_pkg::scan_sample_t sample;
  ipt_pkg::best_t        best;

  assign req_stall  = (state != S_IDLE);
  assign accept     = req_valid && !req_stall;
  assign in_range   = 32'(req.task_id) < 32'(ipt_pkg::TASK_SLOTS);
  assign start_exec = accept && (req.action == ipt_pkg::ACT_EXEC);
  assign rsp_load   = (state == S_FINISH) && (!rsp_valid || !rsp_stall);

  // Store command: request writes, or clearing the winner on completion
  always_comb begin
    cmd.op    = ipt_pkg::SOP_NONE;
    cmd.idx   = ipt_pkg::SLOT_BITS'(req.task_id);
    cmd.prio  = ipt_pkg::PRIORITY_BITS'(req.priority_req);
    cmd.owner = ipt_pkg::USER_BITS'(req.user_id);
    if (accept && in_range) begin
      case (req.action)
        ipt_pkg::ACT_ADD:    cmd.op = ipt_pkg::SOP_ADD;
        ipt_pkg::ACT_EDIT:   cmd.op = ipt_pkg::SOP_EDIT;
        ipt_pkg::ACT_REMOVE: cmd.op = ipt_pkg::SOP_CLEAR;
        default:             cmd.op = ipt_pkg::SOP_NONE;
      endcase
    end
    if (rsp_load && best.have) begin
      cmd.op  = ipt_pkg::SOP_CLEAR;
      cmd.idx = best.idx;
    end
  end

  ipt_store u_store (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .rd_addr  (cnt),
    .rd_valid (rd_valid),
    .rd_prio  (rd_prio),
    .rd_owner (rd_owner)
  );

  // Read data lines up with the index issued in the previous cycle
  always_comb begin
    sample.live  = live_q;
    sample.valid = rd_valid;
    sample.idx   = idx_q;
    sample.prio  = rd_prio;
    sample.owner = rd_owner;
  end

  ipt_best u_best (
    .clk    (clk),
    .rst    (rst),
    .clear  (start_exec),
    .sample (sample),
    .best   (best)
  );

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      live_q    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      live_q <= (state == S_SCAN);
      idx_q  <= cnt;
      // Load at the end of a scan, otherwise drop once transferred
      if (rsp_load) begin
        rsp_valid      <= 1'b1;
        rsp.found      <= best.have;
        rsp.owner_user <= best.have ? 16'(best.owner) : 16'd0;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (start_exec) begin
            state <= S_SCAN;
            cnt   <= '0;
          end
        end
        S_SCAN: begin
          if (cnt == LAST_SLOT) begin
            state <= S_DRAIN;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DRAIN: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (rsp_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/ipt_checker.sv =====
// Port-level checks for the indexed priority task table, bound to the top level.
// Depends on ipt_pkg and indexed_priority_task_table_top.
module ipt_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input ipt_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input ipt_pkg::rsp_t rsp
);

  // A stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // Empty table reports a zero owner
  a_empty_owner: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.found |-> rsp.owner_user == 16'd0)
    else $error("not-found result with non-zero owner");

  // Table writes do not make the block busy
  a_write_one_cycle: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && req.action != ipt_pkg::ACT_EXEC |=> !req_stall)
    else $error("busy after a table write");

  // Execute top starts a scan
  a_exec_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && req.action == ipt_pkg::ACT_EXEC |=> req_stall)
    else $error("not busy after execute top");

  // A new result only appears at the end of a scan
  a_rsp_after_scan: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_stall))
    else $error("result without a scan");

endmodule

bind indexed_priority_task_table_top ipt_checker u_ipt_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

// ===== test/tb.sv =====
// Testbench for the indexed priority task table: directed and random request streams
// with random idling on both channels, checked against an in-bench table predictor.
// Depends on ipt_pkg and indexed_priority_task_table_top.
module tb;

  // Predicts the outcome of each accepted request and holds the pending execute results
  class task_table_scoreboard;
    bit             slot_live [ipt_pkg::TASK_SLOTS];
    ipt_pkg::prio_t slot_prio [ipt_pkg::TASK_SLOTS];
    ipt_pkg::user_t slot_owner[ipt_pkg::TASK_SLOTS];
    ipt_pkg::rsp_t  pending_execs[$];
    int             failures;

    function new();
      foreach (slot_live[i]) slot_live[i] = 1'b0;
      failures = 0;
    endfunction

    // Apply one accepted request to the table copy; execute top queues its outcome
    function void note_request(ipt_pkg::req_t r);
      int            best;
      bit            have;
      ipt_pkg::rsp_t outcome;
      best = 0;
      have = 1'b0;
      if (r.action == ipt_pkg::ACT_EXEC) begin
        // scan upwards, >= so that the highest slot wins a tie
        for (int i = 0; i < ipt_pkg::TASK_SLOTS; i++) begin
          if (slot_live[i] && (!have || slot_prio[i] >= slot_prio[best])) begin
            best = i;
            have = 1'b1;
          end
        end
        outcome.found      = have;
        outcome.owner_user = 16'h0;
        if (have) begin
          slot_live[best]    = 1'b0;
          outcome.owner_user = 16'(slot_owner[best]);
        end
        pending_execs.push_back(outcome);
      end else if (int'(r.task_id) < ipt_pkg::TASK_SLOTS) begin
        case (r.action)
          ipt_pkg::ACT_ADD: begin
            slot_live[r.task_id]  = 1'b1;
            slot_prio[r.task_id]  = ipt_pkg::prio_t'(r.priority_req);
            slot_owner[r.task_id] = ipt_pkg::user_t'(r.user_id);
          end
          ipt_pkg::ACT_EDIT: begin
            if (slot_live[r.task_id]) slot_prio[r.task_id] = ipt_pkg::prio_t'(r.priority_req);
          end
          default: begin
            slot_live[r.task_id] = 1'b0;
          end
        endcase
      end
    endfunction

    // Compare one accepted result with the oldest outstanding execute
    function void check_result(ipt_pkg::rsp_t got);
      ipt_pkg::rsp_t want;
      if (pending_execs.size() == 0) begin
        $display("%0t: unexpected result found=%0b owner=%h", $time, got.found, got.owner_user);
        failures++;
      end else begin
        want = pending_execs.pop_front();
        if (got.found !== want.found) begin
          $display("%0t: found mismatch, expected %0b actual %0b", $time, want.found, got.found);
          failures++;
        end
        if (got.owner_user !== want.owner_user) begin
          $display("%0t: owner mismatch, expected %h actual %h", $time, want.owner_user,
                   got.owner_user);
          failures++;
        end
      end
    endfunction

    function int outstanding();
      return pending_execs.size();
    endfunction
  endclass

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_stall;
  ipt_pkg::req_t req       = '0;
  logic          rsp_valid;
  logic          rsp_stall = 1'b0;
  ipt_pkg::rsp_t rsp;

  int send_idle_pct = 0;
  int rsp_stall_pct = 0;
  task_table_scoreboard board;

  indexed_priority_task_table_top dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #2 clk = ~clk;

  // Receiver back-pressure
  always @(negedge clk) begin
    rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) board.check_result(rsp);
  end

  function automatic ipt_pkg::req_t make_req(ipt_pkg::action_t a, logic [15:0] user,
                                             logic [7:0] tid, logic [31:0] prio);
    ipt_pkg::req_t r;
    r.action       = a;
    r.user_id      = user;
    r.task_id      = tid;
    r.priority_req = prio;
    return r;
  endfunction

  // Priority styles: dense small values for ties, full range, and the extremes
  function automatic logic [31:0] pick_prio(int style);
    logic [31:0] p;
    case (style)
      0:       p = 32'($urandom_range(3));
      1:       p = $urandom;
      default: begin
        case ($urandom_range(3))
          0:       p = 32'h0000_0000;
          1:       p = 32'h0000_0001;
          2:       p = 32'hFFFF_FFFE;
          default: p = 32'hFFFF_FFFF;
        endcase
      end
    endcase
    return p;
  endfunction

  // One request transfer, with random idle cycles ahead of it
  task automatic send_request(input ipt_pkg::req_t r);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (req_stall);
    board.note_request(r);
  endtask

  // Hold off the sender until every outstanding execute has answered
  task automatic drain_results();
    @(negedge clk);
    req_valid <= 1'b0;
    while (board.outstanding() > 0) @(posedge clk);
  endtask

  task automatic run_directed();
    // empty table, fields on execute ignored
    send_request(make_req(ipt_pkg::ACT_EXEC,   16'hFFFF, 8'hFF, 32'hFFFF_FFFF));
    send_request(make_req(ipt_pkg::ACT_ADD,    16'hFFFF, 8'hFF, 32'hFFFF_FFFF));
    send_request(make_req(ipt_pkg::ACT_ADD,    16'h0000, 8'h00, 32'h0000_0000));
    // equal priorities, higher id should win
    send_request(make_req(ipt_pkg::ACT_ADD,    16'h1234, 8'd10, 32'd100));
    send_request(make_req(ipt_pkg::ACT_ADD,    16'h5678, 8'd20, 32'd100));
    // edit and remove of empty slots are no-ops
    send_request(make_req(ipt_pkg::ACT_EDIT,   16'hFFFF, 8'd30, 32'hFFFF_FFFF));
    send_request(make_req(ipt_pkg::ACT_REMOVE, 16'hFFFF, 8'd40, 32'hFFFF_FFFF));
    send_request(make_req(ipt_pkg::ACT_EXEC,   16'h0000, 8'h00, 32'h0));
    send_request(make_req(ipt_pkg::ACT_EXEC,   16'h0000, 8'h00, 32'h0));
    send_request(make_req(ipt_pkg::ACT_EXEC,   16'h0000, 8'h00, 32'h0));
    send_request(make_req(ipt_pkg::ACT_EXEC,   16'h0000, 8'h00, 32'h0));
    send_request(make_req(ipt_pkg::ACT_EXEC,   16'h0000, 8'h00, 32'h0));
    // add over a live slot overwrites owner and priority
    send_request(make_req(ipt_pkg::ACT_ADD,    16'hAAAA, 8'd5, 32'd7));
    send_request(make_req(ipt_pkg::ACT_ADD,    16'h5555, 8'd5, 32'd3));
    send_request(make_req(ipt_pkg::ACT_ADD,    16'h0F0F, 8'd6, 32'd5));
    send_request(make_req(ipt_pkg::ACT_EXEC,   16'h0000, 8'h00, 32'h0));
    send_request(make_req(ipt_pkg::ACT_ADD,    16'h0F0F, 8'd6, 32'd5));
    send_request(make_req(ipt_pkg::ACT_EDIT,   16'h0000, 8'd5, 32'd9));
    send_request(make_req(ipt_pkg::ACT_EXEC,   16'h0000, 8'h00, 32'h0));
    send_request(make_req(ipt_pkg::ACT_REMOVE, 16'h0000, 8'd6, 32'h0));
    send_request(make_req(ipt_pkg::ACT_EXEC,   16'h0000, 8'h00, 32'h0));
    // top bit of the priority compared unsigned
    send_request(make_req(ipt_pkg::ACT_ADD,    16'h8001, 8'd128, 32'h8000_0000));
    send_request(make_req(ipt_pkg::ACT_ADD,    16'h7FFE, 8'd127, 32'h7FFF_FFFF));
    send_request(make_req(ipt_pkg::ACT_EXEC,   16'h0000, 8'h00, 32'h0));
    send_request(make_req(ipt_pkg::ACT_EXEC,   16'h0000, 8'h00, 32'h0));
  endtask

  // Batches of adds into a small id window, some edits and removes, then executes;
  // roughly one round in ten is a single unstructured noise item instead
  task automatic run_random_phase(input int n_items);
    int            sent;
    int            base;
    int            style;
    int            n_add;
    ipt_pkg::req_t r;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        r = make_req(ipt_pkg::action_t'($urandom_range(3)), 16'($urandom), 8'($urandom),
                     $urandom);
        send_request(r);
        sent++;
      end else begin
        base  = $urandom_range(ipt_pkg::TASK_SLOTS - 16);
        style = $urandom_range(2);
        n_add = $urandom_range(10, 2);
        repeat (n_add) begin
          r = make_req(ipt_pkg::ACT_ADD, 16'($urandom), 8'(base + $urandom_range(15)),
                       pick_prio(style));
          send_request(r);
          sent++;
        end
        repeat ($urandom_range(5)) begin
          r = make_req($urandom_range(1) ? ipt_pkg::ACT_EDIT : ipt_pkg::ACT_REMOVE,
                       16'($urandom), 8'(base + $urandom_range(15)), pick_prio(style));
          send_request(r);
          sent++;
        end
        repeat ($urandom_range(n_add + 4, 1)) begin
          send_request(make_req(ipt_pkg::ACT_EXEC, 16'($urandom), 8'($urandom), $urandom));
          sent++;
        end
      end
    end
  endtask

  initial begin
    board = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 15;
    rsp_stall_pct = 56;
    run_directed();
    drain_results();
    run_random_phase(400);
    drain_results();

    send_idle_pct = 56;
    rsp_stall_pct = 15;
    run_random_phase(400);
    drain_results();

    send_idle_pct = 0;
    rsp_stall_pct = 0;
    run_random_phase(400);
    drain_results();

    repeat (ipt_pkg::TASK_SLOTS + 40) @(posedge clk);
    if (board.failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Run limit
  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

endmodule
